// ===== hdl/cdms_pkg.sv =====
// Shared types and constants for the counter delta multiplex scaler.
// Used by cdms_ctrl, cdms_datapath and the top level; depends on nothing.
package cdms_pkg;

   localparam int DATA_W          = 64;
   localparam int CAP_W           = 8;
   localparam int FIELD_W         = 3;
   localparam int STEP_W          = 6;
   localparam int MUL_STEPS       = 4;   // 32x32 partial products in a 64x64 multiply
   localparam int DIV_STEPS       = 64;  // one quotient bit per step
   localparam logic [CAP_W-1:0] SCALE_CAP_RESET = 8'd8;

   // Result source selected when the output register is loaded
   localparam logic [1:0] RES_ZERO = 2'd0;  // failed read
   localparam logic [1:0] RES_RAW  = 2'd1;  // unscaled count delta
   localparam logic [1:0] RES_SAT  = 2'd2;  // quotient overflow, clamped
   localparam logic [1:0] RES_QUO  = 2'd3;  // scaled quotient

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       clear;     // write zeros at the clearing address
      logic       capture;   // latch request, start store read
      logic       delta;     // register the three deltas
      logic       store;     // write the new reading back
      logic       cap_mul;   // running delta times scale cap
      logic       cap_sel;   // cap the enabled delta, clear accumulator
      logic       mul_en;    // one partial product
      logic [1:0] mul_idx;   // which halves: bit 0 count, bit 1 enabled
      logic       acc_en;    // add the last partial product
      logic       div_step;  // one restoring division step
      logic       load_out;  // load the result register
      logic [1:0] res_sel;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;  // clearing address at the final entry
      logic item_ok;     // read succeeded and CPU/slot in range
      logic muxed;       // running delta nonzero and enabled delta above it
      logic div_sat;     // product high half not below the divisor
      logic out_free;    // result register can take a new result
   } dp_status_type;

endpackage

// ===== hdl/cdms_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module cdms_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cdms_datapath.sv =====
// Datapath: reading store, delta subtractors, cap multiply, shared 32x32
// multiplier, restoring divider and result register. Uses cdms_pkg, cdms_ram.
module cdms_datapath #(
   parameter int NUM_SLOTS = 8,
   parameter int NUM_CPUS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cdms_pkg::ctrl_cmd_type        cmd,
   output cdms_pkg::dp_status_type       status,
   // configuration
   input  logic                          csr_valid,
   input  logic [cdms_pkg::CAP_W-1:0]    csr_scale_cap,
   // request payload
   input  logic [cdms_pkg::FIELD_W-1:0]  req_cpu_index,
   input  logic [cdms_pkg::FIELD_W-1:0]  req_slot_index,
   input  logic                          req_read_ok,
   input  logic [cdms_pkg::DATA_W-1:0]   req_counter_value,
   input  logic [cdms_pkg::DATA_W-1:0]   req_time_enabled,
   input  logic [cdms_pkg::DATA_W-1:0]   req_time_running,
   // response
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [cdms_pkg::FIELD_W-1:0]  rsp_out_cpu,
   output logic [cdms_pkg::FIELD_W-1:0]  rsp_out_slot,
   output logic [cdms_pkg::DATA_W-1:0]   rsp_scaled_delta,
   output logic                          rsp_saturated
);

   localparam int DW    = cdms_pkg::DATA_W;
   localparam int DEPTH = NUM_SLOTS * NUM_CPUS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = DW + cdms_pkg::CAP_W;
   localparam int HW    = DW / 2;

   // control registers
   logic [cdms_pkg::CAP_W-1:0]   scale_cap_ff;
   logic [AW-1:0]                clear_addr_ff;
   logic                         rsp_valid_ff;

   // payload registers
   logic [cdms_pkg::FIELD_W-1:0] cpu_ff, slot_ff;
   logic                         ok_ff;
   logic [AW-1:0]                addr_ff;
   logic [DW-1:0]                cnt_ff, en_ff, run_ff;
   logic [DW-1:0]                dcount_ff, den_ff, drun_ff;
   logic [PW-1:0]                capprod_ff;
   logic [DW-1:0]                prod_ff;
   logic [1:0]                   prod_sh_ff;
   logic [2*DW-1:0]              acc_ff;
   logic [cdms_pkg::FIELD_W-1:0] out_cpu_ff, out_slot_ff;
   logic [DW-1:0]                out_delta_ff;
   logic                         out_sat_ff;

   // combinational
   logic                         in_range;
   logic [AW-1:0]                req_addr;
   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic [3*DW-1:0]              mem_wdata;
   logic [3*DW-1:0]              mem_rdata;
   logic [HW-1:0]                mul_a, mul_b;
   logic [2*DW-1:0]              acc_add;
   logic [DW-1:0]                rem_shift;
   logic [DW:0]                  rem_diff;
   logic                         take;
   logic [DW-1:0]                res_delta;
   logic                         res_sat;

   // store address of the incoming request
   always_comb begin
      in_range = (int'(req_cpu_index) < NUM_CPUS) && (int'(req_slot_index) < NUM_SLOTS);
      req_addr = '0;
      if (in_range) begin
         req_addr = AW'(int'(req_slot_index) * NUM_CPUS + int'(req_cpu_index));
      end
   end

   // store write port: clearing pass or write-back of the new reading
   always_comb begin
      mem_we    = cmd.clear | cmd.store;
      mem_waddr = cmd.clear ? clear_addr_ff : addr_ff;
      mem_wdata = cmd.clear ? '0 : {cnt_ff, en_ff, run_ff};
   end

   cdms_ram #(
      .WIDTH(3 * DW),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (cmd.capture),
      .rd_addr(req_addr),
      .rd_data(mem_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_cap_ff  <= cdms_pkg::SCALE_CAP_RESET;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            scale_cap_ff <= csr_scale_cap;
         end
         if (cmd.clear) begin
            clear_addr_ff <= clear_addr_ff + AW'(1);
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // partial product operands
   always_comb begin
      mul_a = cmd.mul_idx[0] ? dcount_ff[DW-1:HW] : dcount_ff[HW-1:0];
      mul_b = cmd.mul_idx[1] ? den_ff[DW-1:HW]    : den_ff[HW-1:0];
   end

   // align the registered partial product
   always_comb begin
      case (prod_sh_ff)
         2'd0:    acc_add = {{DW{1'b0}}, prod_ff};
         2'd1:    acc_add = {{HW{1'b0}}, prod_ff, {HW{1'b0}}};
         default: acc_add = {prod_ff, {DW{1'b0}}};
      endcase
   end

   // restoring division step: remainder in the high half, quotient
   // shifts into the low half
   always_comb begin
      rem_shift = {acc_ff[2*DW-2:DW], acc_ff[DW-1]};
      rem_diff  = {acc_ff[2*DW-1], rem_shift} - {1'b0, drun_ff};
      take      = ~rem_diff[DW];
   end

   // result selection
   always_comb begin
      case (cmd.res_sel)
         cdms_pkg::RES_ZERO: begin
            res_delta = '0;
            res_sat   = 1'b0;
         end
         cdms_pkg::RES_RAW: begin
            res_delta = dcount_ff;
            res_sat   = 1'b0;
         end
         cdms_pkg::RES_SAT: begin
            res_delta = '1;
            res_sat   = 1'b1;
         end
         default: begin
            res_delta = acc_ff[DW-1:0];
            res_sat   = 1'b0;
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cpu_ff  <= req_cpu_index;
         slot_ff <= req_slot_index;
         ok_ff   <= req_read_ok & in_range;
         addr_ff <= req_addr;
         cnt_ff  <= req_counter_value;
         en_ff   <= req_time_enabled;
         run_ff  <= req_time_running;
      end
      if (cmd.delta) begin
         dcount_ff <= cnt_ff - mem_rdata[3*DW-1:2*DW];
         den_ff    <= en_ff  - mem_rdata[2*DW-1:DW];
         drun_ff   <= run_ff - mem_rdata[DW-1:0];
      end
      if (cmd.cap_mul) begin
         capprod_ff <= PW'(drun_ff) * PW'(scale_cap_ff);
      end
      if (cmd.cap_sel) begin
         if ((capprod_ff[PW-1:DW] == '0) && (den_ff > capprod_ff[DW-1:0])) begin
            den_ff <= capprod_ff[DW-1:0];
         end
      end
      if (cmd.mul_en) begin
         prod_ff    <= DW'(mul_a) * DW'(mul_b);
         prod_sh_ff <= {1'b0, cmd.mul_idx[0]} + {1'b0, cmd.mul_idx[1]};
      end
      if (cmd.cap_sel) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + acc_add;
      end else if (cmd.div_step) begin
         acc_ff <= {(take ? rem_diff[DW-1:0] : rem_shift), acc_ff[DW-2:0], take};
      end
      if (cmd.load_out) begin
         out_cpu_ff   <= cpu_ff;
         out_slot_ff  <= slot_ff;
         out_delta_ff <= res_delta;
         out_sat_ff   <= res_sat;
      end
   end

   // status to the controller
   always_comb begin
      status.clear_last = (clear_addr_ff == AW'(DEPTH - 1));
      status.item_ok    = ok_ff;
      status.muxed      = (drun_ff != '0) && (den_ff > drun_ff);
      status.div_sat    = (acc_ff[2*DW-1:DW] >= drun_ff);
      status.out_free   = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_cpu      = out_cpu_ff;
   assign rsp_out_slot     = out_slot_ff;
   assign rsp_scaled_delta = out_delta_ff;
   assign rsp_saturated    = out_sat_ff;

endmodule

// ===== hdl/cdms_ctrl.sv =====
// Controller state machine: clearing pass, request sequencing through the
// delta, cap, multiply and divide steps. Uses cdms_pkg.
module cdms_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cdms_pkg::dp_status_type  status,
   output cdms_pkg::ctrl_cmd_type   cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DELTA  = 4'd2;
   localparam logic [3:0] S_CAP    = 4'd3;
   localparam logic [3:0] S_CAPSEL = 4'd4;
   localparam logic [3:0] S_MUL    = 4'd5;
   localparam logic [3:0] S_DIVCHK = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;

   localparam int SW = cdms_pkg::STEP_W;

   logic [3:0]    state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [1:0]    res_sel_ff, res_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         step_ff    <= '0;
         res_sel_ff <= cdms_pkg::RES_ZERO;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         res_sel_ff <= res_sel_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      res_sel_in = res_sel_ff;
      cmd        = '0;
      cmd.res_sel = res_sel_ff;
      req_ready  = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DELTA;
            end
         end
         S_DELTA: begin
            cmd.delta = 1'b1;
            cmd.store = status.item_ok;
            if (status.item_ok) begin
               state_in = S_CAP;
            end else begin
               res_sel_in = cdms_pkg::RES_ZERO;
               state_in   = S_FINISH;
            end
         end
         S_CAP: begin
            cmd.cap_mul = 1'b1;
            if (status.muxed) begin
               state_in = S_CAPSEL;
            end else begin
               res_sel_in = cdms_pkg::RES_RAW;
               state_in   = S_FINISH;
            end
         end
         S_CAPSEL: begin
            cmd.cap_sel = 1'b1;
            step_in     = '0;
            state_in    = S_MUL;
         end
         S_MUL: begin
            // multiply step k, accumulate product of step k-1
            cmd.mul_en  = (step_ff < SW'(cdms_pkg::MUL_STEPS));
            cmd.mul_idx = step_ff[1:0];
            cmd.acc_en  = (step_ff != '0);
            step_in     = step_ff + SW'(1);
            if (step_ff == SW'(cdms_pkg::MUL_STEPS)) begin
               state_in = S_DIVCHK;
            end
         end
         S_DIVCHK: begin
            step_in = '0;
            if (status.div_sat) begin
               res_sel_in = cdms_pkg::RES_SAT;
               state_in   = S_FINISH;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + SW'(1);
            if (step_ff == SW'(cdms_pkg::DIV_STEPS - 1)) begin
               res_sel_in = cdms_pkg::RES_QUO;
               state_in   = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.load_out = status.out_free;
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/counter_delta_multiplex_scaler_unit.sv =====
// Top level of the counter delta multiplex scaler.
// Uses cdms_pkg, cdms_ctrl, cdms_datapath (and cdms_ram through it).

// Takes one counter reading per request and returns one response with the
// count delta since the last reading of the same CPU and slot, scaled by
// enabled/running time when the event was multiplexed, with the enabled delta
// capped at scale_cap times the running delta; a quotient that overflows 64
// bits is clamped to all ones with rsp_saturated set. After reset the reading
// store is cleared, one entry per cycle, and no request is taken until it is
// done; csr writes are taken at any time. Requests are handled one at a time;
// a scaled delta goes through the 4-step 32x32 multiplier and the 64-step
// restoring divider (one quotient bit per cycle). The response register lets
// the next request be accepted while a response is still waiting.
module counter_delta_multiplex_scaler_unit #(
   parameter int NUM_SLOTS = 8,
   parameter int NUM_CPUS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cdms_pkg::CAP_W-1:0]    csr_scale_cap,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cdms_pkg::FIELD_W-1:0]  req_cpu_index,
   input  logic [cdms_pkg::FIELD_W-1:0]  req_slot_index,
   input  logic                          req_read_ok,
   input  logic [cdms_pkg::DATA_W-1:0]   req_counter_value,
   input  logic [cdms_pkg::DATA_W-1:0]   req_time_enabled,
   input  logic [cdms_pkg::DATA_W-1:0]   req_time_running,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cdms_pkg::FIELD_W-1:0]  rsp_out_cpu,
   output logic [cdms_pkg::FIELD_W-1:0]  rsp_out_slot,
   output logic [cdms_pkg::DATA_W-1:0]   rsp_scaled_delta,
   output logic                          rsp_saturated
);

   cdms_pkg::ctrl_cmd_type  cmd;
   cdms_pkg::dp_status_type status;

   // scale cap register always takes writes
   assign csr_ready = 1'b1;

   cdms_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   cdms_datapath #(
      .NUM_SLOTS(NUM_SLOTS),
      .NUM_CPUS (NUM_CPUS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_scale_cap    (csr_scale_cap),
      .req_cpu_index    (req_cpu_index),
      .req_slot_index   (req_slot_index),
      .req_read_ok      (req_read_ok),
      .req_counter_value(req_counter_value),
      .req_time_enabled (req_time_enabled),
      .req_time_running (req_time_running),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_out_cpu      (rsp_out_cpu),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_scaled_delta (rsp_scaled_delta),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

// ===== dv/cdms_delta_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the counter delta multiplex scaler: follows scale_cap and the
// last good reading of every CPU and slot, predicts each response and compares it.
// Depends on cdms_pkg for field widths and the scale cap reset value.
module cdms_delta_checker #(
   parameter int NUM_SLOTS = 8,
   parameter int NUM_CPUS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [cdms_pkg::CAP_W-1:0]    csr_scale_cap,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [cdms_pkg::FIELD_W-1:0]  req_cpu_index,
   input  logic [cdms_pkg::FIELD_W-1:0]  req_slot_index,
   input  logic                          req_read_ok,
   input  logic [cdms_pkg::DATA_W-1:0]   req_counter_value,
   input  logic [cdms_pkg::DATA_W-1:0]   req_time_enabled,
   input  logic [cdms_pkg::DATA_W-1:0]   req_time_running,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [cdms_pkg::FIELD_W-1:0]  rsp_out_cpu,
   input  logic [cdms_pkg::FIELD_W-1:0]  rsp_out_slot,
   input  logic [cdms_pkg::DATA_W-1:0]   rsp_scaled_delta,
   input  logic                          rsp_saturated,
   output int                            fail_count,
   output int                            pending_count
);

   localparam int DATA_W  = cdms_pkg::DATA_W;
   localparam int CAP_W   = cdms_pkg::CAP_W;
   localparam int FIELD_W = cdms_pkg::FIELD_W;
   localparam int ENTRIES = NUM_SLOTS * NUM_CPUS;

   typedef logic [2*DATA_W-1:0] wide_type;

   typedef struct packed {
      logic [FIELD_W-1:0] cpu;
      logic [FIELD_W-1:0] slot;
      logic [DATA_W-1:0]  delta;
      logic               sat;
   } delta_rsp_type;

   logic [DATA_W-1:0] prev_count   [ENTRIES];
   logic [DATA_W-1:0] prev_enabled [ENTRIES];
   logic [DATA_W-1:0] prev_running [ENTRIES];
   logic [CAP_W-1:0]  cap_now;
   delta_rsp_type     pending_deltas [$];
   int                mismatches = 0;

   // Count delta scaled by enabled/running; enabled delta capped at cap * running
   function automatic logic [DATA_W-1:0] scaled_delta_of(
      input  logic [DATA_W-1:0] dcount,
      input  logic [DATA_W-1:0] den,
      input  logic [DATA_W-1:0] drun,
      input  logic [CAP_W-1:0]  cap,
      output logic              sat
   );
      wide_type          cap_limit;
      wide_type          product;
      logic [DATA_W-1:0] en_used;
      sat = 1'b0;
      // never ran, or not multiplexed: raw delta
      if (drun == '0 || den <= drun)
         return dcount;
      en_used = den;
      // a cap product wider than 64 bits can never be exceeded
      cap_limit = wide_type'(drun) * wide_type'(cap);
      if (cap_limit[2*DATA_W-1:DATA_W] == '0 && den > cap_limit[DATA_W-1:0])
         en_used = cap_limit[DATA_W-1:0];
      product = wide_type'(dcount) * wide_type'(en_used);
      // quotient would not fit in 64 bits
      if (product[2*DATA_W-1:DATA_W] >= drun) begin
         sat = 1'b1;
         return '1;
      end
      product = product / wide_type'(drun);
      return product[DATA_W-1:0];
   endfunction

   function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // Track the state at each accepted csr write and request, check each response
   always @(posedge clock) begin : watch
      delta_rsp_type want;
      logic          sat_bit;
      int            idx;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            prev_count[i]   = '0;
            prev_enabled[i] = '0;
            prev_running[i] = '0;
         end
         cap_now = cdms_pkg::SCALE_CAP_RESET;
         pending_deltas.delete();
      end else begin
         if (csr_valid && csr_ready)
            cap_now = csr_scale_cap;

         if (req_valid && req_ready) begin
            want.cpu   = req_cpu_index;
            want.slot  = req_slot_index;
            want.delta = '0;
            want.sat   = 1'b0;
            // failed or out-of-range read: zero, store untouched
            if (req_read_ok && req_cpu_index < NUM_CPUS && req_slot_index < NUM_SLOTS) begin
               idx = req_slot_index * NUM_CPUS + req_cpu_index;
               want.delta = scaled_delta_of(req_counter_value - prev_count[idx],
                                            req_time_enabled - prev_enabled[idx],
                                            req_time_running - prev_running[idx],
                                            cap_now, sat_bit);
               want.sat = sat_bit;
               prev_count[idx]   = req_counter_value;
               prev_enabled[idx] = req_time_enabled;
               prev_running[idx] = req_time_running;
            end
            pending_deltas.push_back(want);
         end

         if (rsp_valid && rsp_ready) begin
            if (pending_deltas.size() == 0) begin
               mismatches++;
               $display("%0t: response with no request outstanding, expected none,", $time,
                        " actual cpu %0d slot %0d delta %0h sat %0b",
                        rsp_out_cpu, rsp_out_slot, rsp_scaled_delta, rsp_saturated);
            end else begin
               want = pending_deltas.pop_front();
               check_field("out_cpu", DATA_W'(want.cpu), DATA_W'(rsp_out_cpu));
               check_field("out_slot", DATA_W'(want.slot), DATA_W'(rsp_out_slot));
               check_field("scaled_delta", want.delta, rsp_scaled_delta);
               check_field("saturated", DATA_W'(want.sat), DATA_W'(rsp_saturated));
            end
         end
      end
      pending_count <= pending_deltas.size();
      fail_count    <= mismatches;
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the counter delta multiplex scaler testbench: clock, reset, request and
// csr stimulus, response back-pressure and the verdict.
// Depends on cdms_pkg, counter_delta_multiplex_scaler_unit and cdms_delta_checker.
module testbench;

   localparam int DATA_W           = cdms_pkg::DATA_W;
   localparam int CAP_W            = cdms_pkg::CAP_W;
   localparam int FIELD_W          = cdms_pkg::FIELD_W;
   localparam int NUM_SLOTS        = 8;
   localparam int NUM_CPUS         = 8;
   localparam int PHASES           = 6;
   localparam int PHASE_REQS       = 250;
   localparam int CALM_REQS        = 200;  // tail of the run without idling
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 100;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [CAP_W-1:0]   csr_scale_cap;
   logic               req_valid;
   logic               req_ready;
   logic [FIELD_W-1:0] req_cpu_index;
   logic [FIELD_W-1:0] req_slot_index;
   logic               req_read_ok;
   logic [DATA_W-1:0]  req_counter_value;
   logic [DATA_W-1:0]  req_time_enabled;
   logic [DATA_W-1:0]  req_time_running;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [FIELD_W-1:0] rsp_out_cpu;
   logic [FIELD_W-1:0] rsp_out_slot;
   logic [DATA_W-1:0]  rsp_scaled_delta;
   logic               rsp_saturated;
   int                 fail_count;
   int                 pending_count;

   // last good reading sent per CPU and slot, used to build plausible increments
   logic [DATA_W-1:0] sent_count   [NUM_SLOTS*NUM_CPUS];
   logic [DATA_W-1:0] sent_enabled [NUM_SLOTS*NUM_CPUS];
   logic [DATA_W-1:0] sent_running [NUM_SLOTS*NUM_CPUS];

   bit idle_on       = 1'b1;
   int hold_requests = 0;
   int holds_done    = 0;

   counter_delta_multiplex_scaler_unit #(
      .NUM_SLOTS(NUM_SLOTS),
      .NUM_CPUS (NUM_CPUS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_scale_cap    (csr_scale_cap),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cpu_index    (req_cpu_index),
      .req_slot_index   (req_slot_index),
      .req_read_ok      (req_read_ok),
      .req_counter_value(req_counter_value),
      .req_time_enabled (req_time_enabled),
      .req_time_running (req_time_running),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_cpu      (rsp_out_cpu),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_scaled_delta (rsp_scaled_delta),
      .rsp_saturated    (rsp_saturated)
   );

   cdms_delta_checker #(
      .NUM_SLOTS(NUM_SLOTS),
      .NUM_CPUS (NUM_CPUS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_scale_cap    (csr_scale_cap),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cpu_index    (req_cpu_index),
      .req_slot_index   (req_slot_index),
      .req_read_ok      (req_read_ok),
      .req_counter_value(req_counter_value),
      .req_time_enabled (req_time_enabled),
      .req_time_running (req_time_running),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_cpu      (rsp_out_cpu),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_scaled_delta (rsp_scaled_delta),
      .rsp_saturated    (rsp_saturated),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   // Response back-pressure: random stall bursts, plus a long hold on demand
   initial begin
      forever begin
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic logic [DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one request, maybe after an idle burst, and return at its acceptance edge
   task automatic send_abs(input logic [FIELD_W-1:0] cpu, input logic [FIELD_W-1:0] slot,
                           input logic ok, input logic [DATA_W-1:0] cnt,
                           input logic [DATA_W-1:0] en, input logic [DATA_W-1:0] run);
      int idx;
      idx = slot * NUM_CPUS + cpu;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cpu_index     <= cpu;
      req_slot_index    <= slot;
      req_read_ok       <= ok;
      req_counter_value <= cnt;
      req_time_enabled  <= en;
      req_time_running  <= run;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      if (ok) begin
         sent_count[idx]   = cnt;
         sent_enabled[idx] = en;
         sent_running[idx] = run;
      end
   endtask

   // Good read that advances the last reading by the given deltas
   task automatic send_rel(input logic [FIELD_W-1:0] cpu, input logic [FIELD_W-1:0] slot,
                           input logic [DATA_W-1:0] dc, input logic [DATA_W-1:0] de,
                           input logic [DATA_W-1:0] dr);
      int idx;
      idx = slot * NUM_CPUS + cpu;
      send_abs(cpu, slot, 1'b1, sent_count[idx] + dc, sent_enabled[idx] + de,
               sent_running[idx] + dr);
   endtask

   // Stop offering and wait until every request has its response
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_cap(input logic [CAP_W-1:0] cap);
      csr_valid     <= 1'b1;
      csr_scale_cap <= cap;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed increments with random shape, plus failed reads and noise
   task automatic send_random_reading();
      logic [FIELD_W-1:0] cpu;
      logic [FIELD_W-1:0] slot;
      logic [DATA_W-1:0]  dc;
      logic [DATA_W-1:0]  de;
      logic [DATA_W-1:0]  dr;
      int                 pick;
      cpu  = FIELD_W'($urandom);
      slot = FIELD_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         send_abs(cpu, slot, 1'b0, rand64(), rand64(), rand64());
      end else if (pick < 22) begin
         // arbitrary cumulative values: wrapped deltas, overflowing quotients
         send_abs(cpu, slot, 1'b1, rand64(), rand64(), rand64());
      end else begin
         case ($urandom_range(0, 9))
            0:       dr = '0;
            1, 2:    dr = rand64();
            3, 4, 5: dr = $urandom_range(1, 1000);
            default: dr = $urandom;
         endcase
         case ($urandom_range(0, 7))
            0:       de = dr;
            1:       de = dr - $urandom_range(1, 50);
            2:       de = rand64();
            3, 4:    de = dr + $urandom_range(1, 1000);
            default: de = dr + (dr >> $urandom_range(0, 3)) * $urandom_range(1, 64);
         endcase
         case ($urandom_range(0, 5))
            0:       dc = '0;
            1:       dc = rand64();
            2:       dc = $urandom;
            default: dc = $urandom_range(0, 100000);
         endcase
         send_rel(cpu, slot, dc, de, dr);
      end
   endtask

   initial begin
      logic [CAP_W-1:0] phase_cap [PHASES];
      reset             <= 1'b1;
      csr_valid         <= 1'b0;
      csr_scale_cap     <= cdms_pkg::SCALE_CAP_RESET;
      req_valid         <= 1'b0;
      req_cpu_index     <= '0;
      req_slot_index    <= '0;
      req_read_ok       <= 1'b0;
      req_counter_value <= '0;
      req_time_enabled  <= '0;
      req_time_running  <= '0;
      for (int i = 0; i < NUM_SLOTS * NUM_CPUS; i++) begin
         sent_count[i]   = '0;
         sent_enabled[i] = '0;
         sent_running[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at the reset cap
      send_abs(0, 0, 1'b1, '0, '0, '0);
      send_rel(0, 0, 1000, 500, 500);                    // not multiplexed
      send_rel(0, 0, 1000, 300, 100);                    // scaled within cap
      send_rel(0, 0, 1000, 10000, 100);                  // enabled capped
      send_abs(0, 0, 1'b0, '1, '1, '1);                  // failed read
      send_rel(0, 0, 7, 9, 3);                           // store kept across failed read
      send_rel(1, 2, 555, 1000, 0);                      // never ran
      send_rel(1, 2, 100, 50, 80);                       // enabled behind running
      send_rel(3, 4, '1, 20, 10);                        // quotient overflow
      send_rel(3, 4, 64'h8000_0000_0000_0000, 3, 2);     // just fits
      send_rel(5, 6, 12345, 64'hFFFF_FFFF_FFFF_FFFE,
               64'h4000_0000_0000_0000);                 // cap product beyond 64 bits
      send_abs(5, 6, 1'b1, '0, '0, '0);                  // deltas wrap
      send_abs(7, 7, 1'b1, '1, '1, '1);
      send_abs(7, 7, 1'b1, '0, '0, '0);
      send_abs(6, 1, 1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
               64'h5555_5555_5555_5555);
      send_rel(2, 5, 0, 1000, 10);                       // multiplexed, no events
      drain();
      write_cap('0);
      send_rel(2, 5, 500, 400, 100);                     // zero cap kills scaled delta
      drain();
      write_cap('1);
      send_rel(4, 3, 1000, 1000000, 10);
      drain();
      write_cap(8'd1);
      send_rel(4, 3, 1000, 20, 10);

      // Random phases, each under its own cap
      phase_cap[0] = 8'd255;
      phase_cap[1] = 8'd1;
      phase_cap[2] = 8'd0;
      phase_cap[3] = CAP_W'($urandom_range(2, 254));
      phase_cap[4] = cdms_pkg::SCALE_CAP_RESET;
      phase_cap[5] = CAP_W'($urandom_range(1, 255));
      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_cap(phase_cap[p]);
         // hold responses off long enough to back up the request side
         if (p == 1)
            hold_requests++;
         for (int n = 0; n < PHASE_REQS; n++) begin
            if (p == PHASES - 1 && n == PHASE_REQS - CALM_REQS)
               idle_on = 1'b0;
            send_random_reading();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cdms_pkg.sv
hdl/cdms_ram.sv
hdl/cdms_datapath.sv
hdl/cdms_ctrl.sv
hdl/counter_delta_multiplex_scaler_unit.sv
dv/cdms_delta_checker.sv
dv/testbench.sv
